[rtl/sme_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sme_pkg
// Shared opcodes, status codes and the front-to-back instruction record.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int OPQ_DEPTH       = 2;

    localparam logic [7:0] OP_HALT = 8'h00;
    localparam logic [7:0] OP_PUSH = 8'h01;
    localparam logic [7:0] OP_POP  = 8'h02;
    localparam logic [7:0] OP_ADD  = 8'h03;
    localparam logic [7:0] OP_SUB  = 8'h04;
    localparam logic [7:0] OP_MUL  = 8'h05;
    localparam logic [7:0] OP_DIV  = 8'h06;
    localparam logic [7:0] OP_MOD  = 8'h07;
    localparam logic [7:0] OP_CALL = 8'h08;
    localparam logic [7:0] OP_RET  = 8'h09;
    localparam logic [7:0] OP_EQ   = 8'h20;
    localparam logic [7:0] OP_NE   = 8'h21;
    localparam logic [7:0] OP_LT   = 8'h22;
    localparam logic [7:0] OP_GT   = 8'h23;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_HALTED      = 4'd1;
    localparam logic [3:0] ST_NOT_RUNNING = 4'd2;
    localparam logic [3:0] ST_BAD_OP      = 4'd3;
    localparam logic [3:0] ST_OVERFLOW    = 4'd4;
    localparam logic [3:0] ST_UNDERFLOW   = 4'd5;
    localparam logic [3:0] ST_DIV_ZERO    = 4'd6;
    localparam logic [3:0] ST_BAD_JUMP    = 4'd7;
    localparam logic [3:0] ST_NO_PROGRAM  = 4'd8;

    // instruction classes decided in the front end
    typedef enum logic [3:0] {
        CL_HALT, CL_PUSH, CL_POP, CL_BIN, CL_CALL, CL_RET, CL_BAD
    } op_class_t;

    typedef struct packed {
        op_class_t   cls;
        logic [7:0]  op;
        logic [15:0] imm;
    } instr_t;

endpackage : sme_pkg
`default_nettype wire

[rtl/sme_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sme_front
// Accepts instructions, classifies the opcode and queues them for the back end.
// ----------------------------------------------------------------------------
module sme_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      req_type,
    input  wire logic [15:0]     immediate,
    output logic                 q_valid,
    output sme_pkg::instr_t      q_data,
    input  wire logic            q_take
);
    localparam int AW = $clog2(sme_pkg::OPQ_DEPTH);

    sme_pkg::instr_t  mem_reg [sme_pkg::OPQ_DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    sme_pkg::op_class_t cls;
    logic             wr_en, rd_en;

    always_comb
    begin
        unique case (req_type)
            sme_pkg::OP_HALT: cls = sme_pkg::CL_HALT;
            sme_pkg::OP_PUSH: cls = sme_pkg::CL_PUSH;
            sme_pkg::OP_POP:  cls = sme_pkg::CL_POP;
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
            sme_pkg::OP_MOD, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
            sme_pkg::OP_GT:   cls = sme_pkg::CL_BIN;
            sme_pkg::OP_CALL: cls = sme_pkg::CL_CALL;
            sme_pkg::OP_RET:  cls = sme_pkg::CL_RET;
            default:          cls = sme_pkg::CL_BAD;
        endcase
    end

    assign full    = (cnt_reg == (AW+1)'(sme_pkg::OPQ_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_reg] <= '{cls: cls, op: req_type, imm: immediate};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wr_reg <= wr_reg + 1'b1;
            if (rd_en) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule : sme_front
`default_nettype wire

[rtl/sme_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sme_divider
// Signed truncating divide/remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        want_rem,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      result
);
    logic [31:0] q_reg, r_reg, d_reg;
    logic [5:0]  n_reg;
    logic        busy_reg, na_reg, nq_reg, rem_reg;
    logic [32:0] trial;
    logic [31:0] r_sh;

    assign r_sh  = {r_reg[30:0], q_reg[31]};
    assign trial = {1'b0, r_sh} - {1'b0, d_reg};
    assign done  = busy_reg && (n_reg == 6'd0);
    assign result = rem_reg ? (na_reg ? -r_reg : r_reg)
                            : (nq_reg ? -q_reg : q_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= a[31] ? -a : a;
            d_reg   <= b[31] ? -b : b;
            r_reg   <= '0;
            na_reg  <= a[31];
            nq_reg  <= a[31] ^ b[31];
            rem_reg <= want_rem;
        end
        else if (busy_reg && n_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            n_reg    <= 6'd32;
        end
        else if (busy_reg)
        begin
            if (n_reg == 6'd0) busy_reg <= 1'b0;
            else               n_reg <= n_reg - 1'b1;
        end
    end
endmodule : sme_divider
`default_nettype wire

[rtl/sme_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sme_back
// Executes queued instructions against the stack, pc and halt flag.
// ----------------------------------------------------------------------------
module sme_back #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire sme_pkg::instr_t q_data,
    output logic                 q_take,
    input  wire logic [15:0]     prog_len,
    input  wire logic            cfg_wr,
    output logic                 empty,
    input  wire logic            pop,
    output logic [3:0]           status,
    output logic [15:0]          next_pc,
    output logic [7:0]           stack_count,
    output logic signed [31:0]   top_value,
    output logic                 is_halted
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [PW-1:0] FULL_SP = PW'(STACK_DEPTH - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD1  = 8'b0000_0010,
        S_RD2  = 8'b0000_0100,
        S_EXEC = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_WR   = 8'b0100_0000,
        S_RES  = 8'b1000_0000
    } state_t;

    state_t          state_reg;
    logic [31:0]     stk_mem [STACK_DEPTH];
    logic [SW-1:0]   rd_addr;
    logic [31:0]     rd_data_reg;
    logic            mem_we;
    logic [SW-1:0]   wr_addr;
    logic [31:0]     wr_data;

    logic [PW-1:0]   sp_reg;
    logic [15:0]     pc_reg;
    logic            halt_reg;
    logic [31:0]     top_reg;       // cached top entry, also held in memory
    logic [31:0]     below_reg;     // entry under the top pair
    sme_pkg::instr_t ins_reg;
    logic [31:0]     a_reg, b_reg, res_reg;
    logic [3:0]      st_reg;
    logic            out_valid_reg;
    logic [3:0]      o_st_reg;
    logic [15:0]     o_pc_reg;
    logic [7:0]      o_sc_reg;
    logic [31:0]     o_top_reg;
    logic            o_h_reg;
    logic            div_start, div_done;
    logic [31:0]     div_res;

    sme_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .want_rem(ins_reg.op == sme_pkg::OP_MOD),
        .a(a_reg), .b(b_reg), .done(div_done), .result(div_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we) stk_mem[wr_addr] <= wr_data;
        rd_data_reg <= stk_mem[rd_addr];
    end

    // second operand lies one below the top
    assign rd_addr = SW'(sp_reg - PW'(2));
    assign empty   = !out_valid_reg;
    assign status = o_st_reg;
    assign next_pc = o_pc_reg;
    assign stack_count = o_sc_reg;
    assign top_value = o_top_reg;
    assign is_halted = o_h_reg;
    assign q_take = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign div_start = (state_reg == S_EXEC) && ins_reg.cls == sme_pkg::CL_BIN
                       && (ins_reg.op == sme_pkg::OP_DIV || ins_reg.op == sme_pkg::OP_MOD)
                       && prog_len != '0 && !halt_reg && pc_reg < prog_len
                       && sp_reg >= PW'(2) && b_reg != '0;

    logic [31:0] bin_r;
    always_comb
    begin
        case (ins_reg.op)
            sme_pkg::OP_ADD: bin_r = a_reg + b_reg;
            sme_pkg::OP_SUB: bin_r = a_reg - b_reg;
            sme_pkg::OP_EQ:  bin_r = {31'd0, a_reg == b_reg};
            sme_pkg::OP_NE:  bin_r = {31'd0, a_reg != b_reg};
            sme_pkg::OP_LT:  bin_r = {31'd0, $signed(a_reg) < $signed(b_reg)};
            default:         bin_r = {31'd0, $signed(b_reg) < $signed(a_reg)};
        endcase
    end

    // write-through: the new top goes to its own slot once sp has moved
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = SW'(sp_reg - PW'(1));
        wr_data = top_reg;
        if (state_reg == S_WR) mem_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg) out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                pc_reg   <= '0;
                halt_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_take)
                    begin
                        ins_reg   <= q_data;
                        state_reg <= S_RD1;
                    end
                end
                S_RD1:
                begin
                    // read of second entry under way
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    b_reg     <= top_reg;
                    a_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_RES;
                    st_reg    <= sme_pkg::ST_OK;
                    if (prog_len == '0)
                        st_reg <= sme_pkg::ST_NO_PROGRAM;
                    else if (halt_reg || pc_reg >= prog_len)
                        st_reg <= sme_pkg::ST_NOT_RUNNING;
                    else
                    begin
                        unique case (ins_reg.cls)
                            sme_pkg::CL_HALT:
                            begin
                                halt_reg <= 1'b1;
                                st_reg   <= sme_pkg::ST_HALTED;
                            end
                            sme_pkg::CL_PUSH:
                            begin
                                if (sp_reg >= FULL_SP)
                                    st_reg <= sme_pkg::ST_OVERFLOW;
                                else
                                begin
                                    state_reg <= S_WR;
                                    top_reg <= {16'd0, ins_reg.imm};
                                    sp_reg  <= sp_reg + 1'b1;
                                    pc_reg  <= pc_reg + 1'b1;
                                end
                            end
                            sme_pkg::CL_POP:
                            begin
                                if (sp_reg == '0)
                                    st_reg <= sme_pkg::ST_UNDERFLOW;
                                else
                                begin
                                    top_reg <= a_reg;
                                    sp_reg  <= sp_reg - 1'b1;
                                    pc_reg  <= pc_reg + 1'b1;
                                end
                            end
                            sme_pkg::CL_BIN:
                            begin
                                if (sp_reg == '0)
                                    st_reg <= sme_pkg::ST_UNDERFLOW;
                                else if (sp_reg == PW'(1))
                                begin
                                    sp_reg <= '0;
                                    st_reg <= sme_pkg::ST_UNDERFLOW;
                                end
                                else if ((ins_reg.op == sme_pkg::OP_DIV
                                          || ins_reg.op == sme_pkg::OP_MOD) && b_reg == '0)
                                begin
                                    sp_reg  <= sp_reg - PW'(2);
                                    top_reg <= below_reg;
                                    st_reg  <= sme_pkg::ST_DIV_ZERO;
                                end
                                else if (ins_reg.op == sme_pkg::OP_MUL)
                                begin
                                    res_reg   <= a_reg * b_reg;
                                    state_reg <= S_MUL;
                                end
                                else if (ins_reg.op == sme_pkg::OP_DIV
                                         || ins_reg.op == sme_pkg::OP_MOD)
                                    state_reg <= S_DIV;
                                else
                                begin
                                    state_reg <= S_WR;
                                    top_reg <= bin_r;
                                    sp_reg  <= sp_reg - 1'b1;
                                    pc_reg  <= pc_reg + 1'b1;
                                end
                            end
                            sme_pkg::CL_CALL:
                            begin
                                if (ins_reg.imm >= prog_len)
                                    st_reg <= sme_pkg::ST_BAD_JUMP;
                                else if (sp_reg >= FULL_SP)
                                    st_reg <= sme_pkg::ST_OVERFLOW;
                                else
                                begin
                                    state_reg <= S_WR;
                                    top_reg <= {16'd0, pc_reg + 16'd1};
                                    sp_reg  <= sp_reg + 1'b1;
                                    pc_reg  <= ins_reg.imm;
                                end
                            end
                            sme_pkg::CL_RET:
                            begin
                                if (sp_reg == '0)
                                    st_reg <= sme_pkg::ST_UNDERFLOW;
                                else
                                begin
                                    sp_reg  <= sp_reg - 1'b1;
                                    top_reg <= a_reg;
                                    if (b_reg[31] || b_reg >= {16'd0, prog_len})
                                        st_reg <= sme_pkg::ST_BAD_JUMP;
                                    else
                                        pc_reg <= b_reg[15:0];
                                end
                            end
                            default: st_reg <= sme_pkg::ST_BAD_OP;
                        endcase
                    end
                end
                S_MUL:
                begin
                    top_reg   <= res_reg;
                    sp_reg    <= sp_reg - 1'b1;
                    pc_reg    <= pc_reg + 1'b1;
                    state_reg <= S_WR;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        top_reg   <= div_res;
                        sp_reg    <= sp_reg - 1'b1;
                        pc_reg    <= pc_reg + 1'b1;
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    out_valid_reg <= 1'b1;
                    o_st_reg      <= st_reg;
                    o_pc_reg      <= pc_reg;
                    o_sc_reg      <= 8'(sp_reg);
                    o_top_reg     <= (sp_reg == '0) ? '0 : top_reg;
                    o_h_reg       <= halt_reg;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // entry below the popped pair, needed when a divide by zero drops both
    always_ff @(posedge clk)
    begin
        below_reg <= stk_mem[SW'(sp_reg - PW'(3))];
    end
endmodule : sme_back
`default_nettype wire

[rtl/stack_machine_executor_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stack_machine_executor_unit
// Stack machine core: one instruction per transaction, one result per one.
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-------------------------------
// input     | in        | push / full        | req_type, immediate
// result    | out       | pop / empty        | status, next_pc, stack_count,
//           |           |                    | top_value, is_halted
// config    | in        | APB psel/penable   | program_length at 0x0
//
// From the accepting edge to a valid result: RD1, RD2, EXEC and RES for halt, pop,
// ret and any error; push, call, add, sub and compares (stack write) add WR before
// RES, mul adds MUL and WR, and div/mod wait in DIV (one quotient bit a cycle) then WR.
// A two-entry queue lets the front take instructions while the back works.
// Reset clears pc, stack pointer, halt flag, queue and result valid flag;
// stack memory contents are not reset. A pending result stalls the back end.
module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        req_type,
    input  wire logic [15:0]       immediate,
    output logic                   empty,
    input  wire logic              pop,
    output logic [3:0]             status,
    output logic [15:0]            next_pc,
    output logic [7:0]             stack_count,
    output logic signed [31:0]     top_value,
    output logic                   is_halted,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    logic            q_valid, q_take, cfg_wr;
    sme_pkg::instr_t q_data;
    logic [15:0]     prog_len_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {16'd0, prog_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)      prog_len_reg <= '0;
        else if (cfg_wr) prog_len_reg <= pwdata[15:0];
    end

    sme_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .immediate(immediate),
        .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
    );

    sme_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data),
        .q_take(q_take), .prog_len(prog_len_reg), .cfg_wr(cfg_wr),
        .empty(empty), .pop(pop), .status(status), .next_pc(next_pc),
        .stack_count(stack_count), .top_value(top_value), .is_halted(is_halted)
    );
endmodule : stack_machine_executor_unit
`default_nettype wire
